/* rtl/rfa_pkg.sv */
// Package for the rational fraction ALU: widths, microcode encoding, control ROM.
package rfa_pkg;

    // Fixed field widths
    localparam int RES_W             = 33;
    localparam int KIND_W            = 3;
    localparam int FLAG_W            = 4;
    localparam int M_DATA_W          = ((2 * RES_W + 7) / 8) * 8;
    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int STEP_W            = 5;

    // Operation codes carried in kind
    localparam logic [KIND_W-1:0] KIND_ADD = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SUB = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MUL = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DIV = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RED = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CMP = 3'd5;

    typedef logic [STEP_W-1:0] step_t;

    // Sequencer jump control
    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_GOTO,
        JMP_DISPATCH,
        JMP_WAIT,
        JMP_BR_GZ,
        JMP_FINISH
    } jmp_t;

    // Multiplier operand pair
    typedef enum logic [2:0] {
        MS_NA_DB,
        MS_NB_DA,
        MS_NA_NB,
        MS_DA_DB,
        MS_DA_NB
    } mul_sel_t;

    // Accumulator / flag operation
    typedef enum logic [3:0] {
        ACC_NOP,
        ACC_NUM_LD,
        ACC_NUM_ADD,
        ACC_NUM_SUB,
        ACC_DEN_LD,
        ACC_CMP_LD,
        ACC_CMP_EVAL,
        ACC_NUM_Q,
        ACC_DEN_Q,
        ACC_PASS
    } acc_op_t;

    // GCD / divide unit commands
    typedef enum logic [1:0] {
        UOP_NONE,
        UOP_GCD,
        UOP_DIV_NUM,
        UOP_DIV_DEN
    } uop_t;

    // GCD / divide unit state
    typedef enum logic [1:0] {
        U_IDLE,
        U_GCD,
        U_DIV
    } unit_state_t;

    typedef struct packed {
        jmp_t     jmp;
        step_t    target;
        mul_sel_t mul;
        acc_op_t  acc;
        uop_t     uop;
    } cw_t;

    typedef struct packed {
        logic     load_in;
        logic     fin_load;
        mul_sel_t mul;
        acc_op_t  acc;
    } dp_ctrl_t;

    typedef struct packed {
        logic gcd_start;
        logic div_start;
        logic div_den;
    } unit_ctrl_t;

    typedef struct packed {
        logic busy;
        logic g_zero;
    } unit_stat_t;

    // Program entry points
    localparam step_t ADDR_IDLE = 5'd0;
    localparam step_t ADDR_ADD  = 5'd1;
    localparam step_t ADDR_SUB  = 5'd5;
    localparam step_t ADDR_MUL  = 5'd9;
    localparam step_t ADDR_DIV  = 5'd12;
    localparam step_t ADDR_CMP  = 5'd15;
    localparam step_t ADDR_RED  = 5'd18;
    localparam step_t ADDR_ERR  = 5'd26;
    localparam step_t ADDR_FIN  = 5'd27;

    function automatic cw_t make_cw(jmp_t j, step_t t, mul_sel_t m, acc_op_t a, uop_t u);
        cw_t cw;
        cw.jmp    = j;
        cw.target = t;
        cw.mul    = m;
        cw.acc    = a;
        cw.uop    = u;
        return cw;
    endfunction

    // Entry point for each operation; unused kinds go straight out with zeros
    function automatic step_t dispatch(logic [KIND_W-1:0] kind);
        step_t s;
        case (kind)
            KIND_ADD: s = ADDR_ADD;
            KIND_SUB: s = ADDR_SUB;
            KIND_MUL: s = ADDR_MUL;
            KIND_DIV: s = ADDR_DIV;
            KIND_RED: s = ADDR_RED;
            KIND_CMP: s = ADDR_CMP;
            default:  s = ADDR_FIN;
        endcase
        return s;
    endfunction

    // Control store. Multiplier result lands in the product register, read in the step
    // after its operands are selected, so each accumulate trails its multiply.
    function automatic cw_t ucode_rom(step_t addr);
        cw_t cw;
        case (addr)
            ADDR_IDLE:
                cw = make_cw(JMP_DISPATCH, ADDR_IDLE, MS_NA_DB, ACC_NOP, UOP_NONE);
            // add
            ADDR_ADD:
                cw = make_cw(JMP_NEXT, ADDR_IDLE, MS_NA_DB, ACC_NOP, UOP_NONE);
            ADDR_ADD + step_t'(1):
                cw = make_cw(JMP_NEXT, ADDR_IDLE, MS_NB_DA, ACC_NUM_LD, UOP_NONE);
            ADDR_ADD + step_t'(2):
                cw = make_cw(JMP_NEXT, ADDR_IDLE, MS_DA_DB, ACC_NUM_ADD, UOP_NONE);
            ADDR_ADD + step_t'(3):
                cw = make_cw(JMP_GOTO, ADDR_FIN, MS_NA_DB, ACC_DEN_LD, UOP_NONE);
            // subtract
            ADDR_SUB:
                cw = make_cw(JMP_NEXT, ADDR_IDLE, MS_NA_DB, ACC_NOP, UOP_NONE);
            ADDR_SUB + step_t'(1):
                cw = make_cw(JMP_NEXT, ADDR_IDLE, MS_NB_DA, ACC_NUM_LD, UOP_NONE);
            ADDR_SUB + step_t'(2):
                cw = make_cw(JMP_NEXT, ADDR_IDLE, MS_DA_DB, ACC_NUM_SUB, UOP_NONE);
            ADDR_SUB + step_t'(3):
                cw = make_cw(JMP_GOTO, ADDR_FIN, MS_NA_DB, ACC_DEN_LD, UOP_NONE);
            // multiply
            ADDR_MUL:
                cw = make_cw(JMP_NEXT, ADDR_IDLE, MS_NA_NB, ACC_NOP, UOP_NONE);
            ADDR_MUL + step_t'(1):
                cw = make_cw(JMP_NEXT, ADDR_IDLE, MS_DA_DB, ACC_NUM_LD, UOP_NONE);
            ADDR_MUL + step_t'(2):
                cw = make_cw(JMP_GOTO, ADDR_FIN, MS_NA_DB, ACC_DEN_LD, UOP_NONE);
            // divide
            ADDR_DIV:
                cw = make_cw(JMP_NEXT, ADDR_IDLE, MS_NA_DB, ACC_NOP, UOP_NONE);
            ADDR_DIV + step_t'(1):
                cw = make_cw(JMP_NEXT, ADDR_IDLE, MS_DA_NB, ACC_NUM_LD, UOP_NONE);
            ADDR_DIV + step_t'(2):
                cw = make_cw(JMP_GOTO, ADDR_FIN, MS_NA_DB, ACC_DEN_LD, UOP_NONE);
            // compare
            ADDR_CMP:
                cw = make_cw(JMP_NEXT, ADDR_IDLE, MS_NA_DB, ACC_NOP, UOP_NONE);
            ADDR_CMP + step_t'(1):
                cw = make_cw(JMP_NEXT, ADDR_IDLE, MS_NB_DA, ACC_CMP_LD, UOP_NONE);
            ADDR_CMP + step_t'(2):
                cw = make_cw(JMP_GOTO, ADDR_FIN, MS_NA_DB, ACC_CMP_EVAL, UOP_NONE);
            // reduce
            ADDR_RED:
                cw = make_cw(JMP_NEXT, ADDR_IDLE, MS_NA_DB, ACC_NOP, UOP_GCD);
            ADDR_RED + step_t'(1):
                cw = make_cw(JMP_WAIT, ADDR_IDLE, MS_NA_DB, ACC_NOP, UOP_NONE);
            ADDR_RED + step_t'(2):
                cw = make_cw(JMP_BR_GZ, ADDR_ERR, MS_NA_DB, ACC_NOP, UOP_NONE);
            ADDR_RED + step_t'(3):
                cw = make_cw(JMP_NEXT, ADDR_IDLE, MS_NA_DB, ACC_NOP, UOP_DIV_NUM);
            ADDR_RED + step_t'(4):
                cw = make_cw(JMP_WAIT, ADDR_IDLE, MS_NA_DB, ACC_NOP, UOP_NONE);
            ADDR_RED + step_t'(5):
                cw = make_cw(JMP_NEXT, ADDR_IDLE, MS_NA_DB, ACC_NUM_Q, UOP_DIV_DEN);
            ADDR_RED + step_t'(6):
                cw = make_cw(JMP_WAIT, ADDR_IDLE, MS_NA_DB, ACC_NOP, UOP_NONE);
            ADDR_RED + step_t'(7):
                cw = make_cw(JMP_GOTO, ADDR_FIN, MS_NA_DB, ACC_DEN_Q, UOP_NONE);
            // both parts zero: pass through with error
            ADDR_ERR:
                cw = make_cw(JMP_GOTO, ADDR_FIN, MS_NA_DB, ACC_PASS, UOP_NONE);
            ADDR_FIN:
                cw = make_cw(JMP_FINISH, ADDR_IDLE, MS_NA_DB, ACC_NOP, UOP_NONE);
            default:
                cw = make_cw(JMP_GOTO, ADDR_IDLE, MS_NA_DB, ACC_NOP, UOP_NONE);
        endcase
        return cw;
    endfunction

endpackage

/* rtl/rational_fraction_alu_core.sv */
// Top level of the rational fraction ALU: stream ports around sequencer, datapath and GCD unit.
//
//  channel   | direction | tdata (low bit up)              | tuser (low bit up)
//  s_axis    | in        | num_a, den_a, num_b, den_b      | kind
//  m_axis    | out       | res_num, res_den, zero pad      | is_less, is_greater, is_equal, err_zero
//
// Each kind runs its own microcode program from dispatch to the finish step, unused
// kinds go straight to finish; reduce runs longest, as it waits on the binary GCD, one
// step per cycle, and on two divisions, one quotient bit per cycle.
// One transaction is in flight at a time; the next is taken once the result is
// in the output register. A stalled output holds the program at its last step.
// aresetn is synchronous; it clears the step counter, the output valid and the unit state.
module rational_fraction_alu_core #(
    parameter int  OPERAND_WIDTH = rfa_pkg::OPERAND_WIDTH_DEF,
    localparam int S_DATA_W      = ((4 * OPERAND_WIDTH + 7) / 8) * 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // num_a, den_a, num_b, den_b, zero pad
    input  logic [S_DATA_W-1:0]              s_axis_tdata,
    // kind
    input  logic [rfa_pkg::KIND_W-1:0]       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // res_num, res_den, zero pad
    output logic [rfa_pkg::M_DATA_W-1:0]     m_axis_tdata,
    // is_less, is_greater, is_equal, err_zero
    output logic [rfa_pkg::FLAG_W-1:0]       m_axis_tuser
);
    import rfa_pkg::*;

    localparam int W = OPERAND_WIDTH;

    dp_ctrl_t                dp_ctrl;
    unit_ctrl_t              unit_ctrl;
    unit_stat_t              unit_stat;
    logic signed [W-1:0]     na_q, da_q;
    logic signed [RES_W-1:0] quot;
    logic signed [RES_W-1:0] res_num, res_den;

    rfa_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .kind      (s_axis_tuser),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .stat      (unit_stat),
        .dp_ctrl   (dp_ctrl),
        .unit_ctrl (unit_ctrl)
    );

    rfa_dpath #(.W(W)) u_dpath (
        .aclk      (aclk),
        .ctrl      (dp_ctrl),
        .in_na     (s_axis_tdata[W-1:0]),
        .in_da     (s_axis_tdata[2*W-1:W]),
        .in_nb     (s_axis_tdata[3*W-1:2*W]),
        .in_db     (s_axis_tdata[4*W-1:3*W]),
        .quot      (quot),
        .na_q      (na_q),
        .da_q      (da_q),
        .res_num   (res_num),
        .res_den   (res_den),
        .res_flags (m_axis_tuser)
    );

    rfa_gcd_div #(.W(W)) u_gcd_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (unit_ctrl),
        .na      (na_q),
        .da      (da_q),
        .stat    (unit_stat),
        .quot    (quot)
    );

    assign m_axis_tdata = {(M_DATA_W - 2 * RES_W)'(0), res_den, res_num};

endmodule

/* rtl/rfa_gcd_div.sv */
// Iterative binary GCD and restoring divider shared by the reduce program.
module rfa_gcd_div #(
    parameter int W = rfa_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  rfa_pkg::unit_ctrl_t            ctrl,
    input  logic signed [W-1:0]            na,
    input  logic signed [W-1:0]            da,
    output rfa_pkg::unit_stat_t            stat,
    output logic signed [rfa_pkg::RES_W-1:0] quot
);
    import rfa_pkg::*;

    localparam int MW = W + 1;
    localparam int KW = $clog2(W + 1);

    unit_state_t     state_reg, state_next;
    logic [MW-1:0]   x_reg, x_next;
    logic [MW-1:0]   y_reg, y_next;
    logic [KW-1:0]   k_reg, k_next;
    logic [MW-1:0]   g_reg, g_next;
    logic [MW-1:0]   rem_reg, rem_next;
    logic [MW-1:0]   q_reg, q_next;
    logic [KW-1:0]   cnt_reg, cnt_next;
    logic            neg_reg, neg_next;

    logic signed [MW-1:0] na_x, da_x;
    logic [MW-1:0]        na_mag, da_mag;
    logic [MW-1:0]        rem_sh;
    logic [MW:0]          trial;

    // Operand magnitudes, one bit wider so the most negative value fits
    assign na_x   = MW'(na);
    assign da_x   = MW'(da);
    assign na_mag = na_x[MW-1] ? MW'(-na_x) : MW'(na_x);
    assign da_mag = da_x[MW-1] ? MW'(-da_x) : MW'(da_x);

    // Restoring divide trial subtract
    assign rem_sh = {rem_reg[MW-2:0], q_reg[MW-1]};
    assign trial  = {1'b0, rem_sh} - {1'b0, g_reg};

    always_comb begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        k_next     = k_reg;
        g_next     = g_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        case (state_reg)
            U_IDLE: begin
                if (ctrl.gcd_start) begin
                    x_next     = na_mag;
                    y_next     = da_mag;
                    k_next     = '0;
                    state_next = U_GCD;
                end else if (ctrl.div_start) begin
                    q_next     = ctrl.div_den ? da_mag : na_mag;
                    neg_next   = ctrl.div_den ? da[W-1] : na[W-1];
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = U_DIV;
                end
            end
            // One binary GCD step per cycle; a zero part yields the other part shifted left by k_reg
            U_GCD: begin
                if (x_reg == '0) begin
                    g_next     = y_reg << k_reg;
                    state_next = U_IDLE;
                end else if (y_reg == '0) begin
                    g_next     = x_reg << k_reg;
                    state_next = U_IDLE;
                end else if (!x_reg[0] && !y_reg[0]) begin
                    x_next = x_reg >> 1;
                    y_next = y_reg >> 1;
                    k_next = k_reg + KW'(1);
                end else if (!x_reg[0]) begin
                    x_next = x_reg >> 1;
                end else if (!y_reg[0]) begin
                    y_next = y_reg >> 1;
                end else if (x_reg > y_reg) begin
                    x_next = y_reg;
                    y_next = x_reg - y_reg;
                end else begin
                    y_next = y_reg - x_reg;
                end
            end
            // One quotient bit per cycle
            U_DIV: begin
                if (!trial[MW]) begin
                    rem_next = trial[MW-1:0];
                    q_next   = {q_reg[MW-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh;
                    q_next   = {q_reg[MW-2:0], 1'b0};
                end
                cnt_next = cnt_reg + KW'(1);
                if (cnt_reg == KW'(W)) begin
                    state_next = U_IDLE;
                end
            end
            default: begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= U_IDLE;
        end else begin
            state_reg <= state_next;
        end
        x_reg   <= x_next;
        y_reg   <= y_next;
        k_reg   <= k_next;
        g_reg   <= g_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
    end

    assign stat.busy   = (state_reg != U_IDLE);
    assign stat.g_zero = (g_reg == '0);
    assign quot        = neg_reg ? -(RES_W'(q_reg)) : RES_W'(q_reg);

`ifndef NO_ASSERTIONS
    a_start_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.gcd_start || ctrl.div_start) |-> (state_reg == U_IDLE))
        else $error("unit started while busy");

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == U_DIV) |-> (rem_reg < g_reg))
        else $error("partial remainder not below divisor");
`endif

endmodule

/* rtl/rfa_dpath.sv */
// Datapath: operand registers, multiplier, accumulators, compare flags, result register.
module rfa_dpath #(
    parameter int W = rfa_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                              aclk,
    input  rfa_pkg::dp_ctrl_t                 ctrl,
    input  logic signed [W-1:0]               in_na,
    input  logic signed [W-1:0]               in_da,
    input  logic signed [W-1:0]               in_nb,
    input  logic signed [W-1:0]               in_db,
    input  logic signed [rfa_pkg::RES_W-1:0]  quot,
    output logic signed [W-1:0]               na_q,
    output logic signed [W-1:0]               da_q,
    output logic signed [rfa_pkg::RES_W-1:0]  res_num,
    output logic signed [rfa_pkg::RES_W-1:0]  res_den,
    output logic [rfa_pkg::FLAG_W-1:0]        res_flags
);
    import rfa_pkg::*;

    logic signed [W-1:0]       na_reg, da_reg, nb_reg, db_reg;
    logic signed [W-1:0]       ma, mb;
    logic signed [2*W-1:0]     prod_reg, prod_next;
    logic signed [2*W-1:0]     cmp_reg, cmp_next;
    logic signed [RES_W-1:0]   prod_ext;
    logic signed [RES_W-1:0]   num_reg, num_next, den_reg, den_next;
    logic                      lt_reg, lt_next, gt_reg, gt_next;
    logic                      eq_reg, eq_next, err_reg, err_next;
    logic signed [RES_W-1:0]   out_num_reg, out_den_reg;
    logic [FLAG_W-1:0]         out_flags_reg;

    // Multiplier operand select
    always_comb begin
        case (ctrl.mul)
            MS_NA_DB: begin ma = na_reg; mb = db_reg; end
            MS_NB_DA: begin ma = nb_reg; mb = da_reg; end
            MS_NA_NB: begin ma = na_reg; mb = nb_reg; end
            MS_DA_DB: begin ma = da_reg; mb = db_reg; end
            MS_DA_NB: begin ma = da_reg; mb = nb_reg; end
            default:  begin ma = na_reg; mb = db_reg; end
        endcase
    end

    assign prod_next = ma * mb;
    assign prod_ext  = RES_W'(prod_reg);

    // Accumulator and flag update
    always_comb begin
        num_next = num_reg;
        den_next = den_reg;
        cmp_next = cmp_reg;
        lt_next  = lt_reg;
        gt_next  = gt_reg;
        eq_next  = eq_reg;
        err_next = err_reg;
        if (ctrl.load_in) begin
            num_next = '0;
            den_next = '0;
            lt_next  = 1'b0;
            gt_next  = 1'b0;
            eq_next  = 1'b0;
            err_next = 1'b0;
        end else begin
            case (ctrl.acc)
                ACC_NOP:      ;
                ACC_NUM_LD:   num_next = prod_ext;
                ACC_NUM_ADD:  num_next = num_reg + prod_ext;
                ACC_NUM_SUB:  num_next = num_reg - prod_ext;
                ACC_DEN_LD:   den_next = prod_ext;
                ACC_CMP_LD:   cmp_next = prod_reg;
                ACC_CMP_EVAL: begin
                    lt_next = (cmp_reg < prod_reg);
                    gt_next = (cmp_reg > prod_reg);
                    eq_next = (cmp_reg == prod_reg);
                end
                ACC_NUM_Q:    num_next = quot;
                ACC_DEN_Q:    den_next = quot;
                ACC_PASS: begin
                    num_next = RES_W'(na_reg);
                    den_next = RES_W'(da_reg);
                    err_next = 1'b1;
                end
                default:      ;
            endcase
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (ctrl.load_in) begin
            na_reg <= in_na;
            da_reg <= in_da;
            nb_reg <= in_nb;
            db_reg <= in_db;
        end
        prod_reg <= prod_next;
        cmp_reg  <= cmp_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        lt_reg   <= lt_next;
        gt_reg   <= gt_next;
        eq_reg   <= eq_next;
        err_reg  <= err_next;
        if (ctrl.fin_load) begin
            out_num_reg   <= num_reg;
            out_den_reg   <= den_reg;
            out_flags_reg <= {err_reg, eq_reg, gt_reg, lt_reg};
        end
    end

    assign na_q      = na_reg;
    assign da_q      = da_reg;
    assign res_num   = out_num_reg;
    assign res_den   = out_den_reg;
    assign res_flags = out_flags_reg;

endmodule

/* rtl/rfa_seq.sv */
// Microcode sequencer: step counter, control store fetch, jumps and handshakes.
module rfa_seq (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [rfa_pkg::KIND_W-1:0]       kind,
    output logic                             m_valid,
    input  logic                             m_ready,
    input  rfa_pkg::unit_stat_t              stat,
    output rfa_pkg::dp_ctrl_t                dp_ctrl,
    output rfa_pkg::unit_ctrl_t              unit_ctrl
);
    import rfa_pkg::*;

    step_t step_reg, step_next;
    logic  m_valid_reg, m_valid_next;
    cw_t   cw;
    logic  accept;
    logic  out_free;
    logic  fin_load;

    assign cw       = ucode_rom(step_reg);
    assign accept   = (step_reg == ADDR_IDLE) && s_valid;
    assign out_free = !m_valid_reg || m_ready;
    assign fin_load = (cw.jmp == JMP_FINISH) && out_free;

    // Next step
    always_comb begin
        case (cw.jmp)
            JMP_NEXT:     step_next = step_reg + step_t'(1);
            JMP_GOTO:     step_next = cw.target;
            JMP_DISPATCH: step_next = accept ? dispatch(kind) : step_reg;
            JMP_WAIT:     step_next = stat.busy ? step_reg : step_reg + step_t'(1);
            JMP_BR_GZ:    step_next = stat.g_zero ? cw.target : step_reg + step_t'(1);
            JMP_FINISH:   step_next = out_free ? ADDR_IDLE : step_reg;
            default:      step_next = ADDR_IDLE;
        endcase
    end

    // Result slot: filled at finish, emptied by the downstream transaction
    always_comb begin
        if (fin_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= ADDR_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Control fan-out
    assign dp_ctrl.load_in    = accept;
    assign dp_ctrl.fin_load   = fin_load;
    assign dp_ctrl.mul        = cw.mul;
    assign dp_ctrl.acc        = cw.acc;
    assign unit_ctrl.gcd_start = (cw.uop == UOP_GCD);
    assign unit_ctrl.div_start = (cw.uop == UOP_DIV_NUM) || (cw.uop == UOP_DIV_DEN);
    assign unit_ctrl.div_den   = (cw.uop == UOP_DIV_DEN);

    assign s_ready = (step_reg == ADDR_IDLE);
    assign m_valid = m_valid_reg;

`ifndef NO_ASSERTIONS
    a_accept_starts_program: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (step_reg != ADDR_IDLE))
        else $error("accepted transaction did not start a program");

    a_branch_after_gcd: assert property (@(posedge aclk) disable iff (!aresetn)
        (cw.jmp == JMP_BR_GZ) |-> !stat.busy)
        else $error("zero-divisor branch taken before GCD finished");
`endif

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the rational fraction ALU stream core.
`timescale 1ns / 100ps

module testbench;
    import rfa_pkg::*;

    localparam int OPW    = 16;
    localparam int SD_W   = 64;
    localparam int MD_W   = M_DATA_W;

    // Kinds with no operation behind them
    localparam logic [KIND_W-1:0] KIND_SPARE6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE7 = 3'd7;

    // Flag codes as they sit in m_axis_tuser
    localparam logic [3:0] F_NONE = 4'b0000;
    localparam logic [3:0] F_LT   = 4'b0001;
    localparam logic [3:0] F_GT   = 4'b0010;
    localparam logic [3:0] F_EQ   = 4'b0100;
    localparam logic [3:0] F_ERR  = 4'b1000;

    localparam int RANDOM_ITEMS = 1450;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_FROM   = 700;
    localparam int QUIET_TO     = 900;
    localparam int DRAIN_CYCLES = 150;

    typedef logic signed [OPW-1:0] opnd_t;

    typedef struct packed {
        logic err;
        logic eq;
        logic gt;
        logic lt;
    } flags_t;

    typedef struct packed {
        logic [RES_W-1:0] num;
        logic [RES_W-1:0] den;
        flags_t           fl;
    } frac_res_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        opnd_t             na;
        opnd_t             da;
        opnd_t             nb;
        opnd_t             db;
        logic              fixed;
        frac_res_t         want;
    } drill_row_t;

    typedef struct packed {
        logic      fixed;
        frac_res_t want;
    } answer_t;

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [SD_W-1:0]     s_axis_tdata  = '0;
    logic [KIND_W-1:0]   s_axis_tuser  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [MD_W-1:0]     m_axis_tdata;
    logic [FLAG_W-1:0]   m_axis_tuser;

    frac_res_t  pending_results[$];
    answer_t    table_answers[$];
    drill_row_t drill_rows[$];
    int         n_in      = 0;
    int         n_err     = 0;
    int         hold_left = 0;
    bit         hold_done = 1'b0;
    logic       quiet;

    assign quiet = (n_in >= QUIET_FROM) && (n_in < QUIET_TO);

    rational_fraction_alu_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 aclk = ~aclk;

    // Exact fraction arithmetic, 33-bit wrapped results
    function automatic frac_res_t fraction_result(logic [KIND_W-1:0] kind, opnd_t na, opnd_t da,
                                                  opnd_t nb, opnd_t db);
        longint    a, b, c, d, x, y, t, left, right;
        frac_res_t r;
        r = '0;
        a = na;
        b = da;
        c = nb;
        d = db;
        case (kind)
            KIND_ADD: begin
                r.num = RES_W'(a * d + c * b);
                r.den = RES_W'(b * d);
            end
            KIND_SUB: begin
                r.num = RES_W'(a * d - c * b);
                r.den = RES_W'(b * d);
            end
            KIND_MUL: begin
                r.num = RES_W'(a * c);
                r.den = RES_W'(b * d);
            end
            KIND_DIV: begin
                r.num = RES_W'(a * d);
                r.den = RES_W'(b * c);
            end
            KIND_RED: begin
                x = (a < 0) ? -a : a;
                y = (b < 0) ? -b : b;
                while (y != 0) begin
                    t = x % y;
                    x = y;
                    y = t;
                end
                // gcd of zero means both parts were zero: pass through and flag
                if (x == 0) begin
                    r.num    = RES_W'(a);
                    r.den    = RES_W'(b);
                    r.fl.err = 1'b1;
                end else begin
                    r.num = RES_W'(a / x);
                    r.den = RES_W'(b / x);
                end
            end
            KIND_CMP: begin
                left     = a * d;
                right    = c * b;
                r.fl.lt  = left < right;
                r.fl.gt  = left > right;
                r.fl.eq  = left == right;
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic void drill(logic [KIND_W-1:0] kind, opnd_t na, opnd_t da, opnd_t nb,
                                  opnd_t db, logic fixed, logic [RES_W-1:0] wn,
                                  logic [RES_W-1:0] wd, logic [3:0] wf);
        drill_row_t row;
        row.kind      = kind;
        row.na        = na;
        row.da        = da;
        row.nb        = nb;
        row.db        = db;
        row.fixed     = fixed;
        row.want.num  = wn;
        row.want.den  = wd;
        row.want.fl   = flags_t'(wf);
        drill_rows.push_back(row);
    endfunction

    // Half corner and small values, the rest anywhere in range
    function automatic opnd_t rand_operand();
        opnd_t v;
        case ($urandom_range(9))
            0:       v = 16'sh8000;
            1:       v = 16'sh7fff;
            2:       v = '0;
            3, 4:    v = opnd_t'($urandom_range(40)) - 16'sd20;
            default: v = opnd_t'($urandom);
        endcase
        return v;
    endfunction

    // Offer one transaction, with random gaps in front of it outside the quiet window
    task automatic offer(logic [KIND_W-1:0] kind, opnd_t na, opnd_t da, opnd_t nb, opnd_t db,
                         logic fixed, frac_res_t want);
        answer_t ans;
        while (!quiet && $urandom_range(99) < 19) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        ans.fixed = fixed;
        ans.want  = want;
        table_answers.push_back(ans);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {db, nb, da, na};
        s_axis_tuser  <= kind;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // Receiver: random back-pressure, one long hold-off to fill the core
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!hold_done && n_in >= HOLD_AT) begin
            hold_done     <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= quiet || ($urandom_range(99) >= 19);
        end
    end

    // Scoreboard: predict on input transactions, check on output transactions
    always @(posedge aclk) begin
        answer_t   ans;
        frac_res_t want;
        frac_res_t got;
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            ans = table_answers.pop_front();
            if (ans.fixed)
                pending_results.push_back(ans.want);
            else
                pending_results.push_back(fraction_result(s_axis_tuser, s_axis_tdata[15:0],
                    s_axis_tdata[31:16], s_axis_tdata[47:32], s_axis_tdata[63:48]));
            n_in <= n_in + 1;
        end
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.num = m_axis_tdata[RES_W-1:0];
            got.den = m_axis_tdata[2*RES_W-1:RES_W];
            got.fl  = flags_t'(m_axis_tuser);
            if (pending_results.size() == 0) begin
                $error("result transaction with no expectation pending");
                n_err++;
            end else begin
                want = pending_results.pop_front();
                if (got.num !== want.num) begin
                    $error("res_num: expected %0d, got %0d", $signed(want.num), $signed(got.num));
                    n_err++;
                end
                if (got.den !== want.den) begin
                    $error("res_den: expected %0d, got %0d", $signed(want.den), $signed(got.den));
                    n_err++;
                end
                if (got.fl.lt !== want.fl.lt) begin
                    $error("is_less: expected %b, got %b", want.fl.lt, got.fl.lt);
                    n_err++;
                end
                if (got.fl.gt !== want.fl.gt) begin
                    $error("is_greater: expected %b, got %b", want.fl.gt, got.fl.gt);
                    n_err++;
                end
                if (got.fl.eq !== want.fl.eq) begin
                    $error("is_equal: expected %b, got %b", want.fl.eq, got.fl.eq);
                    n_err++;
                end
                if (got.fl.err !== want.fl.err) begin
                    $error("err_zero: expected %b, got %b", want.fl.err, got.fl.err);
                    n_err++;
                end
            end
        end
    end

    // Stimulus and end of run
    initial begin
        logic [KIND_W-1:0] kind;
        opnd_t             na, da, nb, db;
        int                g;

        // Directed table; fixed rows carry their answer, the rest use the predictor
        drill(KIND_ADD, 16'sd0, 16'sd1, 16'sd0, 16'sd1, 1'b1, 33'd0, 33'd1, F_NONE);
        drill(KIND_ADD, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1,
              33'h0_8000_0000, 33'h0_4000_0000, F_NONE);
        drill(KIND_ADD, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, '0, '0, F_NONE);
        drill(KIND_SUB, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 1'b0, '0, '0, F_NONE);
        drill(KIND_SUB, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 1'b0, '0, '0, F_NONE);
        drill(KIND_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1,
              33'h0_4000_0000, 33'h0_4000_0000, F_NONE);
        drill(KIND_MUL, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 1'b0, '0, '0, F_NONE);
        drill(KIND_DIV, 16'sd3, 16'sd4, 16'sd5, 16'sd7, 1'b0, '0, '0, F_NONE);
        // zero denominators are not trapped
        drill(KIND_DIV, 16'sd1, 16'sd0, 16'sd0, 16'sd1, 1'b1, 33'd1, 33'd0, F_NONE);
        drill(KIND_CMP, 16'sh8000, 16'sd1, 16'sh7fff, 16'sd1, 1'b1, 33'd0, 33'd0, F_LT);
        drill(KIND_CMP, 16'sh7fff, 16'sd1, 16'sh8000, 16'sd1, 1'b1, 33'd0, 33'd0, F_GT);
        drill(KIND_CMP, 16'sd1, 16'sd2, 16'sd2, 16'sd4, 1'b1, 33'd0, 33'd0, F_EQ);
        // negative denominator: cross products compared as they are, sign not corrected
        drill(KIND_CMP, 16'sd1, -16'sd2, 16'sd1, 16'sd2, 1'b0, '0, '0, F_NONE);
        // reduce with both parts zero, second fraction ignored
        drill(KIND_RED, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 33'd0, 33'd0, F_ERR);
        drill(KIND_RED, 16'sd0, 16'sd0, 16'sh7fff, 16'sh8000, 1'b1, 33'd0, 33'd0, F_ERR);
        // reduce with one zero part
        drill(KIND_RED, 16'sd0, 16'sd5, 16'sd0, 16'sd0, 1'b1, 33'd0, 33'd1, F_NONE);
        drill(KIND_RED, 16'sd0, 16'sh8000, 16'sd0, 16'sd0, 1'b1,
              33'd0, 33'h1_ffff_ffff, F_NONE);
        drill(KIND_RED, 16'sd7, 16'sd0, 16'sd0, 16'sd0, 1'b1, 33'd1, 33'd0, F_NONE);
        drill(KIND_RED, 16'sh8000, 16'sd0, 16'sd0, 16'sd0, 1'b1,
              33'h1_ffff_ffff, 33'd0, F_NONE);
        drill(KIND_RED, 16'sh8000, 16'sh8000, 16'sd0, 16'sd0, 1'b1,
              33'h1_ffff_ffff, 33'h1_ffff_ffff, F_NONE);
        drill(KIND_RED, 16'sd12, -16'sd18, 16'sd0, 16'sd0, 1'b0, '0, '0, F_NONE);
        drill(KIND_RED, 16'sh7fff, 16'sh8001, 16'sd0, 16'sd0, 1'b0, '0, '0, F_NONE);
        // spare kinds answer with all zeros
        drill(KIND_SPARE6, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 1'b1,
              33'd0, 33'd0, F_NONE);
        drill(KIND_SPARE7, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 1'b1,
              33'd0, 33'd0, F_NONE);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (drill_rows[i])
            offer(drill_rows[i].kind, drill_rows[i].na, drill_rows[i].da, drill_rows[i].nb,
                  drill_rows[i].db, drill_rows[i].fixed, drill_rows[i].want);

        // Random part, with scaled operands to give reduce real common factors
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            kind = KIND_W'($urandom_range(7));
            na   = rand_operand();
            da   = rand_operand();
            nb   = rand_operand();
            db   = rand_operand();
            if (kind == KIND_RED && $urandom_range(2) == 0) begin
                g  = $urandom_range(1, 300);
                na = opnd_t'(g * ($urandom_range(100) - 50));
                da = opnd_t'(g * ($urandom_range(100) - 50));
            end
            if (kind == KIND_CMP && $urandom_range(3) == 0) begin
                nb = na;
                db = da;
            end
            offer(kind, na, da, nb, db, 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;
        // let the scoreboard book the last input transaction
        @(posedge aclk);

        // Drain, then give stray results a chance to show up
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (n_err == 0 && pending_results.size() == 0)
            $display("rational_fraction_alu_core regression: pass");
        else
            $display("rational_fraction_alu_core regression: fail");
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("rational_fraction_alu_core regression: fail");
        $finish;
    end

endmodule
